>>> rtl/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg: shared types and constants of the fixed block free-list allocator
// Item and result layouts, command and register codes, reset values and the
// control bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  // Default pool capacity
  localparam int DEF_MAX_BLOCKS = 256;

  // Field widths fixed by the interface
  localparam int CMD_W      = 1;
  localparam int BLK_W      = 8;
  localparam int OFFSET_W   = 24;
  localparam int COUNT_W    = 9;
  localparam int NBLK_CFG_W = 9;
  localparam int BSIZE_W    = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_BLOCKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 1'b1;

  // Register reset values
  localparam logic [NBLK_CFG_W-1:0] RST_NUM_BLOCKS = 9'd256;
  localparam logic [BSIZE_W-1:0]    RST_BLOCK_SIZE = 17'd64;

  // One input item
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [BLK_W-1:0] block_index;
  } request_t;

  // One result item
  typedef struct packed {
    logic                granted;
    logic [BLK_W-1:0]    result_index;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COUNT_W-1:0]  free_count;
  } result_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic execute;  // update the pool and load the result
  } ctrl_t;

endpackage

>>> rtl/fbfl_ram.sv
// ----------------------------------------------------------------------------
// fbfl_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and returns the
// contents from before a write to the same address in the same cycle.
// ----------------------------------------------------------------------------
module fbfl_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/fbfl_ctrl.sv
// ----------------------------------------------------------------------------
// fbfl_ctrl: allocator controller
// Two-state sequencer: takes an item when idle, runs one execute cycle, then
// strobes done while the next item may already be taken.
// ----------------------------------------------------------------------------
module fbfl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  output fbfl_pkg::ctrl_t ctrl
);

  import fbfl_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  // Sequence one item
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_EXEC);
    end
  end

  assign busy         = (state == ST_EXEC);
  assign ctrl.capture = start && (state == ST_IDLE);
  assign ctrl.execute = (state == ST_EXEC);

  // An accepted item occupies the block for the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // Execute is always followed by a single done strobe and a free block
  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    ctrl.execute |=> (done && !busy))
    else $error("execute cycle not followed by done");

  // Done only follows an execute cycle
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctrl.execute))
    else $error("done without execute");

endmodule

>>> rtl/fbfl_datapath.sv
// ----------------------------------------------------------------------------
// fbfl_datapath: allocator datapath
// Holds the pool registers, the link memory, the configuration registers and
// the result register; applies one allocate or free per execute command.
// ----------------------------------------------------------------------------
module fbfl_datapath #(
  parameter int MAX_BLOCKS = fbfl_pkg::DEF_MAX_BLOCKS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fbfl_pkg::ctrl_t                     ctrl,
  input  fbfl_pkg::request_t                  request,
  input  logic                                cfg_we,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output fbfl_pkg::result_t                   result
);

  import fbfl_pkg::*;

  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int AW     = $clog2(MAX_BLOCKS);
  localparam int PROD_W = CNT_W + BSIZE_W;

  // Clamp the configured block count into 1..MAX_BLOCKS
  function automatic logic [CNT_W-1:0] pool_size(input logic [NBLK_CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > 32'(MAX_BLOCKS)) begin
      r = CNT_W'(MAX_BLOCKS);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  request_t          req_q;
  logic [CNT_W-1:0]  pool_n;
  logic [BSIZE_W-1:0] block_size;
  logic [CNT_W-1:0]  head_index;
  logic [CNT_W-1:0]  free_blocks;
  logic [CNT_W-1:0]  init_count;

  logic              is_alloc;
  logic              lazy_init;
  logic              alloc_ok;
  logic              free_ok;
  logic [CNT_W-1:0]  init_succ;
  logic [CNT_W-1:0]  link_rd;
  logic [CNT_W-1:0]  link_val;
  logic [CNT_W-1:0]  free_dec;
  logic [CNT_W-1:0]  free_blocks_next;
  logic [CNT_W-1:0]  head_index_next;
  logic [CNT_W-1:0]  cfg_n;
  logic [PROD_W-1:0] product;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CNT_W-1:0]  ram_wdata;

  // Link memory; the head's link is read every cycle
  fbfl_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(head_index)),
    .rdata (link_rd)
  );

  // Decode the held item
  assign is_alloc  = (req_q.command == CMD_ALLOC);
  assign lazy_init = is_alloc && (init_count < pool_n);
  assign init_succ = CNT_W'(init_count + 1'b1);
  assign alloc_ok  = is_alloc && (free_blocks != '0) && (head_index < pool_n);
  assign free_ok   = !is_alloc && (32'(req_q.block_index) < 32'(pool_n))
                     && (free_blocks < pool_n);
  assign free_dec  = CNT_W'(free_blocks - 1'b1);

  // Forward the link being built in this same cycle
  assign link_val = (lazy_init && (head_index == init_count)) ? init_succ : link_rd;

  // Link write: lazy build on allocate, push on free
  always_comb begin
    ram_we    = ctrl.execute && (lazy_init || free_ok);
    ram_waddr = AW'(req_q.block_index);
    ram_wdata = (free_blocks == '0) ? pool_n : head_index;
    if (lazy_init) begin
      ram_waddr = AW'(init_count);
      ram_wdata = init_succ;
    end
  end

  // Next head and free count
  always_comb begin
    head_index_next  = head_index;
    free_blocks_next = free_blocks;
    if (alloc_ok) begin
      free_blocks_next = free_dec;
      head_index_next  = (free_dec != '0) ? link_val : pool_n;
    end else if (free_ok) begin
      free_blocks_next = CNT_W'(free_blocks + 1'b1);
      head_index_next  = CNT_W'(req_q.block_index);
    end
  end

  assign cfg_n   = pool_size(cfg_wdata[NBLK_CFG_W-1:0]);
  assign product = PROD_W'(head_index) * PROD_W'(block_size);

  // Latch the item
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      req_q <= request;
    end
  end

  // Pool state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_n      <= pool_size(RST_NUM_BLOCKS);
      block_size  <= RST_BLOCK_SIZE;
      head_index  <= '0;
      free_blocks <= pool_size(RST_NUM_BLOCKS);
      init_count  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_BLOCKS: begin
          pool_n      <= cfg_n;
          head_index  <= '0;
          free_blocks <= cfg_n;
          init_count  <= '0;
        end
        REG_BLOCK_SIZE: begin
          block_size <= cfg_wdata[BSIZE_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (ctrl.execute) begin
      head_index  <= head_index_next;
      free_blocks <= free_blocks_next;
      if (lazy_init) init_count <= init_succ;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctrl.execute) begin
      result.granted      <= alloc_ok || free_ok;
      result.result_index <= alloc_ok ? BLK_W'(head_index) : '0;
      result.byte_offset  <= alloc_ok ? OFFSET_W'(product) : '0;
      result.free_count   <= COUNT_W'(free_blocks_next);
    end
  end

  // Free count never exceeds the pool size
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_blocks <= pool_n)
    else $error("free count above pool size");

  // Lazy build never runs past the pool
  a_init_bound: assert property (@(posedge clk) disable iff (rst)
    init_count <= pool_n)
    else $error("lazy build past pool size");

  // A refused item reports no block and no offset
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (ctrl.execute && !alloc_ok && !free_ok) |=>
      (result.result_index == '0 && result.byte_offset == '0))
    else $error("refused item reports a block");

endmodule

>>> rtl/fixed_block_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator: fixed-size block pool with a free list
// Hands out and takes back block indexes; the free list lives in a link
// memory that is built up one entry per allocate.
// ----------------------------------------------------------------------------
// Each item is accepted at an edge where start is high and busy is low,
// busy is high for the single execute cycle that follows, and the result
// appears on result with done high in the next cycle, for that cycle only.
// The receiver cannot hold a result off, so it must take it when done is
// high. A new item may be started in the same cycle as done, but not while
// busy; this pace is set by the registered read of the link memory at the
// head of the list. The link memory needs no clearing pass after reset.
// Write num_blocks or block_size only while the block is idle; writing
// num_blocks restarts the pool with every block free.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator #(
  parameter int MAX_BLOCKS = fbfl_pkg::DEF_MAX_BLOCKS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  fbfl_pkg::request_t              request,
  output logic                            done,
  output fbfl_pkg::result_t               result,
  input  logic                            cfg_we,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import fbfl_pkg::*;

  ctrl_t ctrl;

  // Sequencer
  fbfl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl)
  );

  // Pool state, link memory and result register
  fbfl_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

endmodule

>>> test/tb_fixed_block_free_list_allocator.sv
// ----------------------------------------------------------------------------
// tb_fixed_block_free_list_allocator: self-checking bench of the block pool
// Drives allocate and free commands through the start/busy port and checks
// every done strobe, field by field, against an in-bench model of the free
// list with lazy link set-up, or a pinned table value. A short directed table
// covers the extremes and the corner cases (empty pool, full pool, index out
// of range, double free, broken list, zero block size, clamped pool size).
// Random phases at several pool and block sizes and sender idle rates follow.
// ----------------------------------------------------------------------------
module tb_fixed_block_free_list_allocator;
  import fbfl_pkg::*;

  localparam int POOL_MAX        = DEF_MAX_BLOCKS;
  localparam int STALL_LIMIT     = 4000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int REPORT_LIMIT    = 10;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  request_t              request;
  logic                  done;
  result_t               result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fixed_block_free_list_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Directed table row: either a command or a register write
  typedef struct {
    bit                    is_reg;
    request_t              op;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] wdata;
    bit                    pinned;
    result_t               want;
  } plan_row_t;

  // Pool model state
  logic [8:0]          link_mem [0:POOL_MAX-1];
  logic [8:0]          head_index;
  logic [8:0]          free_blocks;
  logic [8:0]          init_count;
  logic [NBLK_CFG_W-1:0] num_blocks_cfg;
  logic [BSIZE_W-1:0]  block_size_cfg;

  result_t   pending_results [$];
  int        held_blocks [$];
  plan_row_t directed_plan [$];

  // Expectation typed into the table for the item being offered
  bit      pin_valid;
  result_t pin_result;

  int mismatch_count;
  int stall_cycles;
  int idle_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Effective pool size: zero acts as one, oversize clamps to the maximum
  function automatic logic [8:0] pool_limit();
    if (num_blocks_cfg == '0) return 9'd1;
    if (num_blocks_cfg > POOL_MAX) return 9'(POOL_MAX);
    return num_blocks_cfg;
  endfunction

  function automatic void pool_restart();
    head_index  = '0;
    free_blocks = pool_limit();
    init_count  = '0;
    held_blocks.delete();
  endfunction

  // Apply one command to the model and return the result it must produce
  function automatic result_t pool_apply(request_t op);
    result_t     r;
    logic [8:0]  n;
    logic [8:0]  taken;
    logic [25:0] prod;
    r = '0;
    n = pool_limit();
    if (op.command == CMD_ALLOC) begin
      // extend the lazily built list by one link
      if (init_count < n) begin
        link_mem[init_count[7:0]] = init_count + 9'd1;
        init_count = init_count + 9'd1;
      end
      if (free_blocks != '0 && head_index < n) begin
        taken          = head_index;
        prod           = 26'(taken) * 26'(block_size_cfg);
        r.granted      = 1'b1;
        r.result_index = taken[7:0];
        r.byte_offset  = prod[OFFSET_W-1:0];
        free_blocks    = free_blocks - 9'd1;
        head_index     = (free_blocks != '0) ? link_mem[taken[7:0]] : n;
      end
    end else begin
      if (9'(op.block_index) < n && free_blocks < n) begin
        link_mem[op.block_index] = (free_blocks == '0) ? n : head_index;
        head_index  = 9'(op.block_index);
        free_blocks = free_blocks + 9'd1;
        r.granted   = 1'b1;
      end
    end
    r.free_count = free_blocks;
    return r;
  endfunction

  // Table building
  function automatic void add_op(logic [CMD_W-1:0] cmd, logic [BLK_W-1:0] blk);
    plan_row_t row;
    row = '{default: '0};
    row.op.command     = cmd;
    row.op.block_index = blk;
    directed_plan.push_back(row);
  endfunction

  function automatic void add_op_known(logic [CMD_W-1:0] cmd, logic [BLK_W-1:0] blk,
                                       result_t want);
    plan_row_t row;
    row = '{default: '0};
    row.op.command     = cmd;
    row.op.block_index = blk;
    row.pinned         = 1'b1;
    row.want           = want;
    directed_plan.push_back(row);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = '{default: '0};
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.wdata   = data;
    directed_plan.push_back(row);
  endfunction

  function automatic void flag_mismatch(string what, result_t want, result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%s: expected g=%0d idx=%0d off=%0d cnt=%0d, got g=%0d idx=%0d off=%0d cnt=%0d",
               what, want.granted, want.result_index, want.byte_offset, want.free_count,
               got.granted, got.result_index, got.byte_offset, got.free_count);
  endfunction

  // Offer one item, with sender idling, and hold it until accepted
  task automatic issue_op(request_t op, bit pinned, result_t want);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start      <= 1'b1;
    request    <= op;
    pin_valid  <= pinned;
    pin_result <= want;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and drain every outstanding result
  task automatic settle();
    @(negedge clk);
    start     <= 1'b0;
    pin_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Pick a random command: mostly proper alloc/free traffic, some noise
  function automatic request_t pick_op();
    request_t op;
    int       slot;
    op.command     = CMD_ALLOC;
    op.block_index = BLK_W'($urandom_range(255));
    if ($urandom_range(99) < 85) begin
      if (held_blocks.size() != 0 && $urandom_range(1) == 1) begin
        slot           = $urandom_range(held_blocks.size() - 1);
        op.command     = CMD_FREE;
        op.block_index = BLK_W'(held_blocks[slot]);
      end
    end else begin
      op.command = CMD_FREE;
      // aim near the top of the pool now and then
      if ($urandom_range(1) == 1)
        op.block_index = BLK_W'(int'(pool_limit()) - 2 + $urandom_range(3));
    end
    return op;
  endfunction

  // Sample, predict and check at the rising edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < POOL_MAX; i++) link_mem[i] = '0;
      num_blocks_cfg = RST_NUM_BLOCKS;
      block_size_cfg = RST_BLOCK_SIZE;
      pool_restart();
      stall_cycles = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NUM_BLOCKS) begin
          num_blocks_cfg = cfg_wdata[NBLK_CFG_W-1:0];
          pool_restart();
        end else begin
          block_size_cfg = cfg_wdata[BSIZE_W-1:0];
        end
      end
      if (start && !busy) begin
        want = pool_apply(request);
        // track blocks handed out so that frees can return them
        if (want.granted && request.command == CMD_ALLOC) begin
          held_blocks.push_back(int'(want.result_index));
        end else if (want.granted) begin
          foreach (held_blocks[i]) begin
            if (held_blocks[i] == int'(request.block_index)) begin
              held_blocks.delete(i);
              break;
            end
          end
        end
        if (pin_valid) want = pin_result;
        pending_results.push_back(want);
      end
      if (done) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result with nothing outstanding", '0, result);
        end else begin
          want = pending_results.pop_front();
          if (result.granted !== want.granted || result.result_index !== want.result_index ||
              result.byte_offset !== want.byte_offset || result.free_count !== want.free_count)
            flag_mismatch("result mismatch", want, result);
        end
      end
      // watchdog on a stuck handshake
      if ((start && !busy) || done || cfg_we) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    logic [8:0]  nblk;
    logic [16:0] bsize;
    request_t    op;
    start          = 1'b0;
    request        = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_NUM_BLOCKS;
    cfg_wdata      = '0;
    pin_valid      = 1'b0;
    pin_result     = '0;
    mismatch_count = 0;
    idle_pct       = 0;
    rst            = 1'b1;

    // After reset: 256 blocks of 64 bytes
    add_op_known(CMD_ALLOC, 8'h00, '{1'b1, 8'd0, 24'd0, 9'd255});
    add_op_known(CMD_ALLOC, 8'h5A, '{1'b1, 8'd1, 24'd64, 9'd254});
    add_op_known(CMD_FREE,  8'hFF, '{1'b1, 8'd0, 24'd0, 9'd255});
    add_op_known(CMD_ALLOC, 8'hA5, '{1'b1, 8'd255, 24'd16320, 9'd254});
    add_op(CMD_FREE, 8'h00);
    add_op_known(CMD_FREE,  8'h01, '{1'b1, 8'd0, 24'd0, 9'd256});
    // full pool: free ignored
    add_op_known(CMD_FREE,  8'h07, '{1'b0, 8'd0, 24'd0, 9'd256});
    add_reg(REG_BLOCK_SIZE, 17'd0);
    add_op_known(CMD_ALLOC, 8'hFF, '{1'b1, 8'd1, 24'd0, 9'd255});
    // two blocks, largest block size; double free of a not yet linked block
    add_reg(REG_NUM_BLOCKS, 17'd2);
    add_reg(REG_BLOCK_SIZE, 17'h1FFFF);
    add_op_known(CMD_ALLOC, 8'h00, '{1'b1, 8'd0, 24'd0, 9'd1});
    add_op_known(CMD_FREE,  8'h01, '{1'b1, 8'd0, 24'd0, 9'd2});
    add_op_known(CMD_ALLOC, 8'h00, '{1'b1, 8'd1, 24'd131071, 9'd1});
    // broken list: head past the end while blocks are still counted free
    add_op_known(CMD_ALLOC, 8'h00, '{1'b0, 8'd0, 24'd0, 9'd1});
    add_op_known(CMD_FREE,  8'h02, '{1'b0, 8'd0, 24'd0, 9'd1});
    add_op(CMD_FREE, 8'h00);
    add_op(CMD_ALLOC, 8'h00);
    // one block: empty pool, then free into empty
    add_reg(REG_NUM_BLOCKS, 17'd1);
    add_op_known(CMD_ALLOC, 8'h00, '{1'b1, 8'd0, 24'd0, 9'd0});
    add_op_known(CMD_ALLOC, 8'h00, '{1'b0, 8'd0, 24'd0, 9'd0});
    add_op_known(CMD_FREE,  8'h01, '{1'b0, 8'd0, 24'd0, 9'd0});
    add_op_known(CMD_FREE,  8'h00, '{1'b1, 8'd0, 24'd0, 9'd1});
    add_op_known(CMD_ALLOC, 8'h00, '{1'b1, 8'd0, 24'd0, 9'd0});
    // oversize pool clamps to the maximum; largest offset
    add_reg(REG_NUM_BLOCKS, 17'h1FFFF);
    add_reg(REG_BLOCK_SIZE, 17'h10000);
    add_op_known(CMD_ALLOC, 8'h00, '{1'b1, 8'd0, 24'd0, 9'd255});
    add_op_known(CMD_FREE,  8'hFF, '{1'b1, 8'd0, 24'd0, 9'd256});
    add_op_known(CMD_ALLOC, 8'h00, '{1'b1, 8'd255, 24'd16711680, 9'd255});
    // zero pool size acts as one block
    add_reg(REG_NUM_BLOCKS, 17'd0);
    add_op_known(CMD_ALLOC, 8'h00, '{1'b1, 8'd0, 24'd0, 9'd0});
    add_op_known(CMD_ALLOC, 8'h00, '{1'b0, 8'd0, 24'd0, 9'd0});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_reg) begin
        settle();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].wdata);
      end else begin
        issue_op(directed_plan[i].op, directed_plan[i].pinned, directed_plan[i].want);
      end
    end

    // Random phases: new pool and block size each time, varying sender idling
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin nblk = 9'd1;                         bsize = 17'd1;     end
        1:       begin nblk = 9'(POOL_MAX);                  bsize = 17'h1FFFF; end
        2:       begin nblk = 9'($urandom_range(2, 6));      bsize = 17'($urandom); end
        3:       begin nblk = 9'($urandom_range(7, 32));     bsize = 17'd0;     end
        4:       begin nblk = 9'h1FF;                        bsize = 17'h10000; end
        5:       begin nblk = 9'd0;                          bsize = 17'($urandom); end
        6:       begin nblk = 9'($urandom_range(2, 12));     bsize = 17'd64;    end
        default: begin nblk = 9'($urandom_range(1, POOL_MAX)); bsize = 17'($urandom); end
      endcase
      case (p % 4)
        1:       idle_pct = 80;
        3:       idle_pct = 34;
        default: idle_pct = 0;
      endcase
      settle();
      // upper data bits are don't-care for the pool size register
      if ($urandom_range(1) == 1) begin
        write_reg(REG_BLOCK_SIZE, bsize);
        write_reg(REG_NUM_BLOCKS, {8'($urandom), nblk});
      end else begin
        write_reg(REG_NUM_BLOCKS, {8'($urandom), nblk});
        write_reg(REG_BLOCK_SIZE, bsize);
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // hold off mid-phase until the pipe is empty
        if (k == ITEMS_PER_PHASE / 2) settle();
        op = pick_op();
        issue_op(op, 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
